>>> sv/rwh_pkg.sv
package rwh_pkg;

   // Fixed-point format of hues and wheel angles
   localparam int HUE_FRAC_BITS = 7;
   localparam int ONE           = 1 << HUE_FRAC_BITS;
   localparam int FULL          = 360 * ONE;
   localparam int SEG_LEN       = 15 * ONE;

   // Port and internal widths
   localparam int HUE_W   = 16;
   localparam int ANG_W   = 16;
   localparam int VAL_W   = $clog2(FULL + 1);
   localparam int SUM_W   = VAL_W + 2;
   localparam int SEG_W   = 5;
   localparam int DY_W    = 5;
   localparam int DIST_W  = HUE_FRAC_BITS + 5;
   localparam int ROT_W   = 10;
   localparam int FWD_W   = HUE_FRAC_BITS + 4;
   localparam int INV_W   = HUE_FRAC_BITS + 5;

   // Wheel table: HSV hue at each 15 degree step of the RYB wheel
   localparam int KNOTS = 25;
   localparam int SEGS  = KNOTS - 1;
   localparam int unsigned KNOT_TBL [KNOTS] = '{
      0, 8, 17, 26, 34, 41, 48, 54, 60, 81, 103, 123, 138,
      155, 171, 187, 204, 219, 234, 251, 267, 282, 298, 329, 360
   };

   // Rotation reduction: rem 360 through a reciprocal multiply
   localparam int ANG_MOD   = 360;
   localparam int ANG_SHIFT = 24;
   localparam longint ANG_RCP = ((64'd1 << ANG_SHIFT) + ANG_MOD - 1) / ANG_MOD;
   localparam int QUO_W     = 7;

   // Forward map: divide by 2*dy through a per-segment reciprocal
   localparam int NUM1_W  = HUE_FRAC_BITS + 10;
   localparam int SHIFT1  = HUE_FRAC_BITS + 17;
   localparam int RCP1_W  = HUE_FRAC_BITS + 14;

   // Segment of a wrapped wheel angle: whole degrees divided by 15
   localparam int DEG_W     = 9;
   localparam int DIV15_RCP = 2185;
   localparam int DIV15_SH  = 15;
   localparam int DIV15_W   = 12;

   // Inverse map: divide by 30 through a reciprocal
   localparam int NUM2_W  = HUE_FRAC_BITS + 10;
   localparam int SHIFT2  = HUE_FRAC_BITS + 16;
   localparam int RCP2_W  = HUE_FRAC_BITS + 12;
   localparam longint RCP2 = ((64'd1 << SHIFT2) + 29) / 30;

   // Classified request passed from front to back
   typedef struct packed {
      logic [SEG_W-1:0]        seg;
      logic [DIST_W-1:0]       ofs;
      logic signed [ROT_W-1:0] rot;
   } rwh_item_type;

endpackage

>>> sv/rwh_fifo.sv
// Small register queue; DEPTH is a power of two
module rwh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign count   = count_ff;

endmodule

>>> sv/rwh_front.sv
// Front: accept requests, reduce the rotation and find the wheel segment of the hue
module rwh_front
   import rwh_pkg::*;
#(
   parameter int MID_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [HUE_W-1:0]               req_hue_in,
   input  logic signed [ANG_W-1:0]        req_angle_deg,
   input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
   output logic                           mid_push,
   output rwh_item_type                   mid_item
);

   localparam int CNT_W = $clog2(MID_DEPTH + 1);

   logic                    accept;
   logic [VAL_W-1:0]        hue_red;
   logic [ANG_W-1:0]        mag;
   logic [2*ANG_W-1:0]      quo_prod;
   logic [ANG_W-1:0]        rem_full;
   logic [DEG_W-1:0]        rem;
   logic [SEGS-1:0]         le_knot;
   logic [SEG_W-1:0]        seg;

   logic                    f1_valid_ff;
   logic [VAL_W-1:0]        f1_hue_ff;
   logic [ANG_W-1:0]        f1_mag_ff;
   logic                    f1_neg_ff;
   logic [QUO_W-1:0]        f1_quo_ff;

   // Hold off requests when the queue plus the stage in flight could overflow
   assign req_full = ({1'b0, mid_count} + (CNT_W+1)'(f1_valid_ff)) >= (CNT_W+1)'(MID_DEPTH);
   assign accept   = req_push & ~req_full;

   // Fold the hue into one turn; take magnitude and quotient of the rotation
   always_comb begin
      if (32'(req_hue_in) >= 32'(FULL)) begin
         hue_red = VAL_W'(32'(req_hue_in) - 32'(FULL));
      end else begin
         hue_red = VAL_W'(req_hue_in);
      end
      mag      = req_angle_deg[ANG_W-1] ? ANG_W'(-req_angle_deg) : ANG_W'(req_angle_deg);
      quo_prod = (2*ANG_W)'(mag) * (2*ANG_W)'(ANG_RCP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_hue_ff <= hue_red;
         f1_mag_ff <= mag;
         f1_neg_ff <= req_angle_deg[ANG_W-1];
         f1_quo_ff <= quo_prod[ANG_SHIFT +: QUO_W];
      end
   end

   // Finish the remainder and locate the first knot at or above the hue
   always_comb begin
      rem_full = f1_mag_ff - ANG_W'(f1_quo_ff) * ANG_W'(ANG_MOD);
      rem      = rem_full[DEG_W-1:0];
      for (int k = 0; k < SEGS; k++) begin
         le_knot[k] = 32'(f1_hue_ff) <= KNOT_TBL[k+1] * 32'(ONE);
      end
      seg = SEG_W'(SEGS - 1);
      for (int k = SEGS - 1; k >= 0; k--) begin
         if (le_knot[k]) begin
            seg = SEG_W'(k);
         end
      end
   end

   // Pass the classified request to the queue
   always_comb begin
      mid_push      = f1_valid_ff;
      mid_item.seg  = seg;
      mid_item.ofs  = DIST_W'(f1_hue_ff - VAL_W'(KNOT_TBL[seg] * 32'(ONE)));
      mid_item.rot  = f1_neg_ff ? -ROT_W'({1'b0, rem}) : ROT_W'({1'b0, rem});
   end

endmodule

>>> sv/rwh_back.sv
// Back: map to the RYB wheel, rotate, wrap and map back to an HSV hue
module rwh_back
   import rwh_pkg::*;
#(
   parameter int OUT_DEPTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           mid_empty,
   input  rwh_item_type                   mid_item,
   output logic                           mid_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                           out_push,
   output logic [HUE_W-1:0]               out_hue
);

   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
   localparam int BUSY_W = (OCNT_W > 3) ? OCNT_W + 1 : 4;

   // Per-segment width and reciprocal of twice the width
   logic [DY_W-1:0]   dy_tbl  [SEGS];
   logic [RCP1_W-1:0] rcp_tbl [SEGS];

   for (genvar g = 0; g < SEGS; g++) begin : g_seg
      localparam longint DY  = longint'(KNOT_TBL[g+1]) - longint'(KNOT_TBL[g]);
      localparam longint RCP = ((64'd1 << SHIFT1) + 2*DY - 1) / (2*DY);
      assign dy_tbl[g]  = DY_W'(DY);
      assign rcp_tbl[g] = RCP1_W'(RCP);
   end

   logic [BUSY_W-1:0]               busy;
   logic [NUM1_W-1:0]               num1;
   logic [NUM1_W+RCP1_W-1:0]        prod1;
   logic [VAL_W-1:0]                ryb;
   logic signed [SUM_W-1:0]         sum;
   logic signed [SUM_W-1:0]         sum_wrap;
   logic [DEG_W-1:0]                deg;
   logic [DIV15_W+DEG_W-1:0]        prod15;
   logic [SEG_W-1:0]                seg3;
   logic [NUM2_W+RCP2_W-1:0]        prod2;
   logic [VAL_W-1:0]                hue;

   logic                    b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic [SEG_W-1:0]        b1_seg_ff;
   logic [FWD_W-1:0]        b1_fwd_ff;
   logic signed [ROT_W-1:0] b1_rot_ff;
   logic [VAL_W-1:0]        b2_sum_ff;
   logic [SEG_W-1:0]        b3_seg_ff;
   logic [FWD_W-1:0]        b3_ofs_ff;
   logic [SEG_W-1:0]        b4_seg_ff;
   logic [NUM2_W-1:0]       b4_num_ff;

   // Pull a request only when the result queue has room for everything in flight
   always_comb begin
      busy = BUSY_W'(out_count) + BUSY_W'(b1_valid_ff) + BUSY_W'(b2_valid_ff)
           + BUSY_W'(b3_valid_ff) + BUSY_W'(b4_valid_ff);
      mid_pop = ~mid_empty & (busy < BUSY_W'(OUT_DEPTH));
   end

   // Stage 1: offset into segment scaled to 15 degrees, rounded half up
   always_comb begin
      num1  = NUM1_W'(mid_item.ofs) * NUM1_W'(30) + NUM1_W'(dy_tbl[mid_item.seg]);
      prod1 = (NUM1_W+RCP1_W)'(num1) * (NUM1_W+RCP1_W)'(rcp_tbl[mid_item.seg]);
   end

   // Stage 2: add the rotation and wrap into one turn
   always_comb begin
      ryb = VAL_W'(b1_seg_ff) * VAL_W'(SEG_LEN) + VAL_W'(b1_fwd_ff);
      sum = SUM_W'(ryb) + (SUM_W'(b1_rot_ff) <<< HUE_FRAC_BITS);
      if (sum < 0) begin
         sum_wrap = sum + SUM_W'(FULL);
      end else if (sum >= SUM_W'(FULL)) begin
         sum_wrap = sum - SUM_W'(FULL);
      end else begin
         sum_wrap = sum;
      end
   end

   // Stage 3: segment of the wrapped angle and offset inside it
   always_comb begin
      deg    = DEG_W'(b2_sum_ff >> HUE_FRAC_BITS);
      prod15 = (DIV15_W+DEG_W)'(deg) * (DIV15_W+DEG_W)'(DIV15_RCP);
      seg3   = prod15[DIV15_SH +: SEG_W];
   end

   // Stage 4 result: divide by 30, add the knot hue and wrap
   always_comb begin
      prod2 = (NUM2_W+RCP2_W)'(b4_num_ff) * (NUM2_W+RCP2_W)'(RCP2);
      hue   = VAL_W'(KNOT_TBL[b4_seg_ff] * 32'(ONE)) + VAL_W'(prod2[SHIFT2 +: INV_W]);
      if (hue >= VAL_W'(FULL)) begin
         out_hue = HUE_W'(hue - VAL_W'(FULL));
      end else begin
         out_hue = HUE_W'(hue);
      end
      out_push = b4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= mid_pop;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      b1_seg_ff <= mid_item.seg;
      b1_fwd_ff <= prod1[SHIFT1 +: FWD_W];
      b1_rot_ff <= mid_item.rot;
      b2_sum_ff <= VAL_W'(sum_wrap);
      b3_seg_ff <= seg3;
      b3_ofs_ff <= FWD_W'(b2_sum_ff - VAL_W'(seg3) * VAL_W'(SEG_LEN));
      b4_seg_ff <= b3_seg_ff;
      b4_num_ff <= (NUM2_W'(dy_tbl[b3_seg_ff]) * NUM2_W'(b3_ofs_ff) << 1) + NUM2_W'(15);
   end

endmodule

>>> sv/ryb_wheel_hue_rotate_unit.sv
// Channel   Ports                                   Handshake
// request   req_hue_in, req_angle_deg               req_push / req_full
// response  rsp_hue_out                             rsp_pop / rsp_empty
//
// One request per cycle sustained while req_full is low. A taken request passes the front
// stage, the classify queue, the four back stages and the result queue in that order before
// its response shows on the result ports.
// Synchronous reset empties both queues and the pipeline; no other state.
// A stalled consumer fills the result queue, then the classify queue, then raises req_full.
module ryb_wheel_hue_rotate_unit
   import rwh_pkg::*;
#(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [HUE_W-1:0]        req_hue_in,
   input  logic signed [ANG_W-1:0] req_angle_deg,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [HUE_W-1:0]        rsp_hue_out
);

   localparam int MCNT_W = $clog2(MID_DEPTH + 1);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

   logic                  mid_push;
   logic                  mid_pop;
   logic                  mid_empty;
   logic [MCNT_W-1:0]     mid_count;
   rwh_item_type          mid_wr_item;
   rwh_item_type          mid_rd_item;
   logic                  out_push;
   logic [HUE_W-1:0]      out_hue;
   logic [OCNT_W-1:0]     out_count;

   rwh_front #(
      .MID_DEPTH (MID_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_hue_in    (req_hue_in),
      .req_angle_deg (req_angle_deg),
      .mid_count     (mid_count),
      .mid_push      (mid_push),
      .mid_item      (mid_wr_item)
   );

   rwh_fifo #(
      .WIDTH ($bits(rwh_item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_wr_item),
      .pop     (mid_pop),
      .rd_data (mid_rd_item),
      .empty   (mid_empty),
      .count   (mid_count)
   );

   rwh_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_rd_item),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_hue   (out_hue)
   );

   rwh_fifo #(
      .WIDTH (HUE_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_hue),
      .pop     (rsp_pop & ~rsp_empty),
      .rd_data (rsp_hue_out),
      .empty   (rsp_empty),
      .count   (out_count)
   );

endmodule

>>> tb/sv/ryb_rotate_checker.sv
`timescale 1ns / 100ps

module ryb_rotate_checker
   import rwh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic                    req_full,
   input  logic [HUE_W-1:0]        req_hue_in,
   input  logic signed [ANG_W-1:0] req_angle_deg,
   input  logic                    rsp_empty,
   input  logic                    rsp_pop,
   input  logic [HUE_W-1:0]        rsp_hue_out,
   output int                      mismatch_count,
   output int                      rotations_pending
);

   // Wheel geometry in fixed-point degrees
   localparam longint UNIT      = longint'(1) << HUE_FRAC_BITS;
   localparam longint TURN      = 360 * UNIT;
   localparam longint STEP      = 15 * UNIT;
   localparam int     WHEEL_PTS = 25;
   localparam int     LAST_SEG  = WHEEL_PTS - 2;
   localparam int     REPORT_MAX = 10;

   // HSV hue at every 15 degrees of the artistic wheel
   localparam longint WHEEL_HUE [WHEEL_PTS] = '{
      0, 8, 17, 26, 34, 41, 48, 54, 60, 81, 103, 123, 138,
      155, 171, 187, 204, 219, 234, 251, 267, 282, 298, 329, 360
   };

   typedef struct {
      logic [HUE_W-1:0]        hue;
      logic signed [ANG_W-1:0] angle;
      logic [HUE_W-1:0]        rotated;
   } rotation_type;

   rotation_type rotated_hue_q [$];

   assign rotations_pending = rotated_hue_q.size();

   // Map hue onto the wheel, turn it, and map it back
   function automatic logic [HUE_W-1:0] predict_rotated_hue(
      input logic [HUE_W-1:0]        hue_raw,
      input logic signed [ANG_W-1:0] angle_raw
   );
      longint hue;
      longint turn;
      longint wheel;
      longint seg;
      longint span;
      longint ofs;
      longint hsv;
      int     k;
      hue  = longint'(hue_raw) % TURN;
      turn = longint'(angle_raw) % 360;
      // lowest segment whose upper knot is not below the hue
      seg = LAST_SEG;
      for (k = 0; k < LAST_SEG + 1; k++) begin
         if (hue <= WHEEL_HUE[k+1] * UNIT) begin
            seg = k;
            break;
         end
      end
      span  = WHEEL_HUE[seg+1] - WHEEL_HUE[seg];
      ofs   = hue - WHEEL_HUE[seg] * UNIT;
      wheel = seg * STEP + (30 * ofs + span) / (2 * span) + turn * UNIT;
      // wrap into one turn, negative sums included
      if (wheel < 0) begin
         wheel += TURN;
      end else if (wheel >= TURN) begin
         wheel -= TURN;
      end
      seg = wheel / STEP;
      if (seg > LAST_SEG) begin
         seg = LAST_SEG;
      end
      ofs  = wheel - seg * STEP;
      span = WHEEL_HUE[seg+1] - WHEEL_HUE[seg];
      hsv  = (WHEEL_HUE[seg] * UNIT + (2 * span * ofs + 15) / 30) % TURN;
      return hsv[HUE_W-1:0];
   endfunction

   always @(posedge clock) begin : watch_channels
      rotation_type oldest;
      if (reset) begin
         mismatch_count = 0;
      end else begin
         // compare each popped response with the oldest prediction
         if (rsp_pop && !rsp_empty) begin
            if (rotated_hue_q.size() == 0) begin
               if (mismatch_count < REPORT_MAX)
                  $display("%0t: response hue_out=%0d with no request outstanding",
                           $time, rsp_hue_out);
               mismatch_count++;
            end else begin
               oldest = rotated_hue_q.pop_front();
               if (rsp_hue_out !== oldest.rotated) begin
                  if (mismatch_count < REPORT_MAX)
                     $display("%0t: hue_in=%0d angle=%0d: hue_out expected %0d, got %0d",
                              $time, oldest.hue, oldest.angle, oldest.rotated,
                              rsp_hue_out);
                  mismatch_count++;
               end
            end
         end
         // predict every accepted request
         if (req_push && !req_full) begin
            oldest.hue     = req_hue_in;
            oldest.angle   = req_angle_deg;
            oldest.rotated = predict_rotated_hue(req_hue_in, req_angle_deg);
            rotated_hue_q.push_back(oldest);
         end
      end
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import rwh_pkg::*;

   localparam int HUE_TURN     = 360 << HUE_FRAC_BITS;
   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_AT      = 750;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 24;
   localparam int DIRECTED     = 23;

   // Edges of the fields, knots, wrap cases and dense bit patterns
   localparam logic [HUE_W-1:0] DIR_HUE [DIRECTED] = '{
      16'd0, 16'd46079, 16'd46080, 16'd65535, 16'd0, 16'd0, 16'd1000, 16'd1000,
      16'd5000, 16'd5000, 16'd0, 16'd0, 16'd46079, 16'd1024, 16'd7680, 16'd42112,
      16'd38144, 16'd42113, 16'd128, 16'd23040, 16'd21760, 16'hAAAA, 16'h5555
   };
   localparam logic [ANG_W-1:0] DIR_ANGLE [DIRECTED] = '{
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sh8000, 16'sd360, -16'sd360,
      16'sd359, -16'sd359, -16'sd1, -16'sd15, 16'sd1, 16'sd15, -16'sd15, 16'sd15,
      16'sd0, 16'sd0, 16'sd359, 16'sd180, -16'sd180, 16'h5555, 16'hAAAA
   };

   typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_PERIODIC} pop_mode_type;

   logic                    clock;
   logic                    reset;
   logic                    req_push;
   logic                    req_full;
   logic [HUE_W-1:0]        req_hue_in;
   logic signed [ANG_W-1:0] req_angle_deg;
   logic                    rsp_empty;
   logic                    rsp_pop;
   logic [HUE_W-1:0]        rsp_hue_out;

   int mismatch_count;
   int rotations_pending;
   int burst_left;
   int stall_cycles;

   ryb_wheel_hue_rotate_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_hue_in    (req_hue_in),
      .req_angle_deg (req_angle_deg),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_hue_out   (rsp_hue_out)
   );

   ryb_rotate_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_hue_in        (req_hue_in),
      .req_angle_deg     (req_angle_deg),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_hue_out       (rsp_hue_out),
      .mismatch_count    (mismatch_count),
      .rotations_pending (rotations_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Pick a hue: mostly in range, some at or next to whole degrees, some past a turn
   function automatic logic [HUE_W-1:0] pick_hue();
      int unsigned sel;
      int          h;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         h = $urandom_range(0, HUE_TURN - 1);
      end else if (sel < 75) begin
         h = ($urandom_range(0, 360) << HUE_FRAC_BITS) + $urandom_range(0, 2) - 1;
      end else if (sel < 90) begin
         h = $urandom_range(HUE_TURN, 65535);
      end else begin
         h = $urandom;
      end
      return h[HUE_W-1:0];
   endfunction

   // Pick a rotation: small turns, whole wheel steps, full range and edges
   function automatic logic [ANG_W-1:0] pick_angle();
      int unsigned sel;
      int          a;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         a = int'($urandom_range(0, 1440)) - 720;
      end else if (sel < 60) begin
         a = int'($urandom_range(0, 96)) * 15 - 720;
      end else if (sel < 85) begin
         a = $urandom;
      end else begin
         case ($urandom_range(0, 6))
            0:       a = 32767;
            1:       a = -32768;
            2:       a = 359;
            3:       a = -359;
            4:       a = 360;
            5:       a = -360;
            default: a = 0;
         endcase
      end
      return a[ANG_W-1:0];
   endfunction

   // Present one request, hold it until taken, then maybe idle for a while
   task automatic send_request(input logic [HUE_W-1:0] hue, input logic [ANG_W-1:0] angle);
      int gap;
      req_push      <= 1'b1;
      req_hue_in    <= hue;
      req_angle_deg <= angle;
      do @(posedge clock); while (req_full);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop sending and wait until every prediction has been matched
   task automatic drain_rotations();
      req_push <= 1'b0;
      do @(posedge clock); while (rotations_pending != 0);
   endtask

   // Response side: stall on a pattern that changes mode now and then
   initial begin : pop_pattern
      pop_mode_type pop_mode;
      int           phase_left;
      int           tick;
      rsp_pop    = 1'b0;
      pop_mode   = POP_ALWAYS;
      phase_left = 0;
      tick       = 0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            pop_mode   = pop_mode_type'($urandom_range(0, 3));
            phase_left = $urandom_range(32, 400);
         end
         phase_left--;
         tick++;
         case (pop_mode)
            POP_ALWAYS:   rsp_pop <= 1'b1;
            POP_COIN:     rsp_pop <= 1'($urandom_range(0, 1));
            POP_SPARSE:   rsp_pop <= ($urandom_range(0, 7) == 0);
            POP_PERIODIC: rsp_pop <= ((tick % 11) < 4);
            default:      rsp_pop <= 1'b1;
         endcase
      end
   end

   // Watchdog: end the run when neither side moves for too long
   initial begin : watchdog
      stall_cycles = 0;
      do begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall_cycles = 0;
         else
            stall_cycles++;
      end while (stall_cycles < STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int n;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_hue_in    = '0;
      req_angle_deg = '0;
      burst_left    = $urandom_range(1, 40);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      for (n = 0; n < DIRECTED; n++) begin
         send_request(DIR_HUE[n], DIR_ANGLE[n]);
      end

      // random requests, with one full drain part way through
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT) begin
            drain_rotations();
         end
         send_request(pick_hue(), pick_angle());
      end

      drain_rotations();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && rotations_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
sv/rwh_pkg.sv
sv/rwh_fifo.sv
sv/rwh_front.sv
sv/rwh_back.sv
sv/ryb_wheel_hue_rotate_unit.sv
tb/sv/ryb_rotate_checker.sv
tb/sv/tb_top.sv
